### sv/stt_pkg.sv
package stt_pkg;

  // Defaults for the top-level parameters.
  localparam int OFFSET_BITS_DEF   = 16;
  localparam int KEYWORD_COUNT_DEF = 18;

  // Keyword table size, results per byte and queue depth.
  localparam int KW_TABLE    = 18;
  localparam int MAX_RES     = 5;
  localparam int QUEUE_DEPTH = 2;
  localparam int CNT_W       = $clog2(MAX_RES + 1);

  // Token kinds.
  localparam logic [5:0] K_LPAREN  = 6'd0;
  localparam logic [5:0] K_RPAREN  = 6'd1;
  localparam logic [5:0] K_LBRACE  = 6'd2;
  localparam logic [5:0] K_RBRACE  = 6'd3;
  localparam logic [5:0] K_COMMA   = 6'd4;
  localparam logic [5:0] K_DOT     = 6'd5;
  localparam logic [5:0] K_MINUS   = 6'd6;
  localparam logic [5:0] K_PLUS    = 6'd7;
  localparam logic [5:0] K_SEMI    = 6'd8;
  localparam logic [5:0] K_STAR    = 6'd9;
  localparam logic [5:0] K_QUEST   = 6'd10;
  localparam logic [5:0] K_COLON   = 6'd11;
  localparam logic [5:0] K_BANG    = 6'd12;
  localparam logic [5:0] K_BANG_EQ = 6'd13;
  localparam logic [5:0] K_SLASH   = 6'd20;
  localparam logic [5:0] K_SPACE   = 6'd21;
  localparam logic [5:0] K_NEWLINE = 6'd22;
  localparam logic [5:0] K_STRING  = 6'd23;
  localparam logic [5:0] K_NUMBER  = 6'd24;
  localparam logic [5:0] K_IDENT   = 6'd25;
  localparam logic [5:0] K_KW0     = 6'd26;
  localparam logic [5:0] K_END     = 6'd44;

  // Error codes.
  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_UNEXPECTED = 2'd1;
  localparam logic [1:0] ERR_UNTERM     = 2'd2;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [15:0] start_offset;
    logic [15:0] lexeme_length;
    logic [15:0] repeat_count;
    logic [15:0] line_number;
    logic [1:0]  error_code;
    logic        last_result;
  } out_item_t;

  // One result without its end marker.
  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] start;
    logic [15:0] len;
    logic [15:0] rep;
    logic [15:0] line;
    logic [1:0]  err;
  } token_t;

  // All results caused by one byte.
  typedef struct packed {
    token_t [MAX_RES-1:0] tok;
    logic [CNT_W-1:0]     count;
  } bundle_t;

  // Keyword text, packed with the first character highest.
  function automatic logic [55:0] kw_word(input int i);
    logic [55:0] w;
    case (i)
      0:       w = "and";
      1:       w = "class";
      2:       w = "else";
      3:       w = "elif";
      4:       w = "false";
      5:       w = "for";
      6:       w = "def";
      7:       w = "if";
      8:       w = "NOPE";
      9:       w = "or";
      10:      w = "print";
      11:      w = "return";
      12:      w = "super";
      13:      w = "this";
      14:      w = "true";
      15:      w = "while";
      16:      w = "in";
      17:      w = "is";
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic logic [15:0] kw_len(input int i);
    logic [15:0] n;
    case (i)
      0, 5, 6:                n = 16'd3;
      1, 4, 10, 12, 15:       n = 16'd5;
      2, 3, 8, 13, 14:        n = 16'd4;
      7, 9, 16, 17:           n = 16'd2;
      11:                     n = 16'd6;
      default:                n = 16'd0;
    endcase
    return n;
  endfunction

endpackage

### sv/stt_stream_if.sv
interface stt_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/stt_front.sv
module stt_front #(
  parameter int OFFSET_BITS   = stt_pkg::OFFSET_BITS_DEF,
  parameter int KEYWORD_COUNT = stt_pkg::KEYWORD_COUNT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  stt_pkg::in_item_t in_data_i,
  output logic              in_ready_o,
  input  logic              q_full_i,
  output logic              q_push_o,
  output stt_pkg::bundle_t  q_data_o
);
  import stt_pkg::*;

  typedef enum logic [8:0] {
    M_IDLE    = 9'b000000001,
    M_OP      = 9'b000000010,
    M_SLASH   = 9'b000000100,
    M_COMMENT = 9'b000001000,
    M_STRING  = 9'b000010000,
    M_IDENT   = 9'b000100000,
    M_INT     = 9'b001000000,
    M_DOT     = 9'b010000000,
    M_FRAC    = 9'b100000000
  } mode_e;

  mode_e                  mode_q, mode_d;
  logic [1:0]             pend_q, pend_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [OFFSET_BITS-1:0] tstart_q, tstart_d;
  logic [15:0]            line_q, line_d;
  logic                   lht_q, lht_d;
  logic [15:0]            sp_cnt_q, sp_cnt_d;
  logic [OFFSET_BITS-1:0] sp_start_q, sp_start_d;
  logic [55:0]            kw_q, kw_d;
  logic [15:0]            len_q, len_d;
  logic [15:0]            sline_q, sline_d;
  bundle_t                b;
  logic                   done, broken, accept;
  logic [7:0]             c;
  logic [OFFSET_BITS-1:0] at;

  function automatic logic [15:0] off16(input logic [OFFSET_BITS-1:0] x);
    logic [31:0] t;
    t = 32'(x);
    return t[15:0];
  endfunction

  function automatic logic [15:0] inc16(input logic [15:0] x);
    return (x == 16'hFFFF) ? x : x + 16'd1;
  endfunction

  function automatic token_t mk(input logic [5:0] kind, input logic [15:0] start,
                                input logic [15:0] len, input logic [15:0] rep,
                                input logic [15:0] line, input logic [1:0] err);
    token_t t;
    t.kind  = kind;
    t.start = start;
    t.len   = len;
    t.rep   = rep;
    t.line  = line;
    t.err   = err;
    return t;
  endfunction

  // Results beyond the limit are dropped.
  function automatic bundle_t push(input bundle_t bi, input token_t t);
    bundle_t bo;
    bo = bi;
    if (bo.count < CNT_W'(MAX_RES)) begin
      bo.tok[bo.count[$clog2(MAX_RES)-1:0]] = t;
      bo.count = bo.count + CNT_W'(1);
    end
    return bo;
  endfunction

  // A token flushes any held space run ahead of itself.
  function automatic bundle_t put(input bundle_t bi, input logic [15:0] spc,
                                  input logic [15:0] sps, input logic [15:0] line,
                                  input logic [5:0] kind, input logic [15:0] start,
                                  input logic [15:0] len);
    bundle_t bo;
    bo = bi;
    if (spc != 16'd0) bo = push(bo, mk(K_SPACE, sps, 16'd1, spc, line, ERR_NONE));
    bo = push(bo, mk(kind, start, len, 16'd1, line, ERR_NONE));
    return bo;
  endfunction

  // Keyword lookup over the whole table at once; the first match wins.
  function automatic logic [5:0] word_kind(input logic [15:0] len, input logic [55:0] w);
    logic [5:0] k;
    k = K_IDENT;
    for (int i = KW_TABLE - 1; i >= 0; i--) begin
      if (i < KEYWORD_COUNT && len == kw_len(i) && w == kw_word(i)) k = K_KW0 + 6'(i);
    end
    return k;
  endfunction

  function automatic logic is_digit(input logic [7:0] x);
    return x >= "0" && x <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] x);
    return (x >= "a" && x <= "z") || (x >= "A" && x <= "Z") || x == "_";
  endfunction

  assign c          = in_data_i.char_byte;
  assign at         = pos_q;
  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign q_push_o   = accept && (b.count != '0);
  assign q_data_o   = b;

  // Scanner step for one byte: finish the open token, start a new one, close at end.
  always_comb begin
    mode_d = mode_q; pend_d = pend_q; pos_d = pos_q + OFFSET_BITS'(1);
    tstart_d = tstart_q; line_d = line_q; lht_d = lht_q; sp_cnt_d = sp_cnt_q;
    sp_start_d = sp_start_q; kw_d = kw_q; len_d = len_q; sline_d = sline_q;
    b = '0; done = 1'b0; broken = 1'b0;

    unique case (mode_q)
      M_OP: begin
        mode_d = M_IDLE;
        b = put(b, sp_cnt_d, off16(sp_start_d), line_d,
                K_BANG + {3'b000, pend_q, (c == "=")}, off16(tstart_q),
                (c == "=") ? 16'd2 : 16'd1);
        sp_cnt_d = '0; lht_d = 1'b1;
        done = (c == "=");
      end
      M_SLASH: begin
        if (c == "/") begin
          mode_d = M_COMMENT; done = 1'b1;
        end else begin
          mode_d = M_IDLE;
          b = put(b, sp_cnt_d, off16(sp_start_d), line_d, K_SLASH, off16(tstart_q), 16'd1);
          sp_cnt_d = '0; lht_d = 1'b1;
        end
      end
      M_COMMENT: begin
        if (c == "\n") mode_d = M_IDLE;
        else done = 1'b1;
      end
      M_STRING: begin
        done = 1'b1;
        len_d = inc16(len_q);
        if (c == "\"") begin
          mode_d = M_IDLE;
          b = put(b, sp_cnt_d, off16(sp_start_d), line_d, K_STRING, off16(tstart_q), len_d);
          sp_cnt_d = '0;
        end else if (c == "\n") begin
          line_d = inc16(line_q);
        end
      end
      M_IDENT: begin
        if (is_alpha(c) || is_digit(c)) begin
          if (len_q < 16'd7) kw_d = {kw_q[47:0], c};
          len_d = inc16(len_q);
          done = 1'b1;
        end else begin
          mode_d = M_IDLE;
          b = put(b, sp_cnt_d, off16(sp_start_d), line_d, word_kind(len_q, kw_q),
                  off16(tstart_q), len_q);
          sp_cnt_d = '0; lht_d = 1'b1;
        end
      end
      M_INT: begin
        if (is_digit(c)) begin
          len_d = inc16(len_q); done = 1'b1;
        end else if (c == ".") begin
          mode_d = M_DOT; done = 1'b1;
        end else begin
          mode_d = M_IDLE;
          b = put(b, sp_cnt_d, off16(sp_start_d), line_d, K_NUMBER, off16(tstart_q), len_q);
          sp_cnt_d = '0;
        end
      end
      M_DOT: begin
        if (is_digit(c)) begin
          len_d = inc16(inc16(len_q)); mode_d = M_FRAC; done = 1'b1;
        end else begin
          // The dot was not part of the number after all.
          mode_d = M_IDLE;
          b = put(b, sp_cnt_d, off16(sp_start_d), line_d, K_NUMBER, off16(tstart_q), len_q);
          sp_cnt_d = '0;
          b = push(b, mk(K_DOT, off16(at - OFFSET_BITS'(1)), 16'd1, 16'd1, line_d, ERR_NONE));
          lht_d = 1'b1;
        end
      end
      M_FRAC: begin
        if (is_digit(c)) begin
          len_d = inc16(len_q); done = 1'b1;
        end else begin
          mode_d = M_IDLE;
          b = put(b, sp_cnt_d, off16(sp_start_d), line_d, K_NUMBER, off16(tstart_q), len_q);
          sp_cnt_d = '0;
        end
      end
      default: mode_d = M_IDLE;
    endcase

    // Byte that starts something new.
    if (!done) begin
      case (c)
        "(", ")", "{", "}", ",", ".", "-", "+", ";", "*", "?", ":": begin
          logic [5:0] k;
          case (c)
            "(":     k = K_LPAREN;
            ")":     k = K_RPAREN;
            "{":     k = K_LBRACE;
            "}":     k = K_RBRACE;
            ",":     k = K_COMMA;
            ".":     k = K_DOT;
            "-":     k = K_MINUS;
            "+":     k = K_PLUS;
            ";":     k = K_SEMI;
            "*":     k = K_STAR;
            "?":     k = K_QUEST;
            default: k = K_COLON;
          endcase
          b = put(b, sp_cnt_d, off16(sp_start_d), line_d, k, off16(at), 16'd1);
          sp_cnt_d = '0; lht_d = 1'b1;
        end
        "!", "=", "<", ">": begin
          mode_d = M_OP; tstart_d = at;
          case (c)
            "!":     pend_d = 2'd0;
            "=":     pend_d = 2'd1;
            "<":     pend_d = 2'd2;
            default: pend_d = 2'd3;
          endcase
        end
        "/": begin
          mode_d = M_SLASH; tstart_d = at;
        end
        " ": begin
          if (!lht_d) begin
            if (sp_cnt_d == 16'd0) sp_start_d = at;
            sp_cnt_d = inc16(sp_cnt_d);
          end
        end
        "\r", "\t": ;
        "\n": begin
          sp_cnt_d = '0;
          b = push(b, mk(K_NEWLINE, off16(at), 16'd1, 16'd1, line_d, ERR_NONE));
          lht_d = 1'b0;
          line_d = inc16(line_d);
        end
        "\"": begin
          mode_d = M_STRING; tstart_d = at; len_d = 16'd1; sline_d = line_d;
        end
        default: begin
          if (is_digit(c)) begin
            mode_d = M_INT; tstart_d = at; len_d = 16'd1;
          end else if (is_alpha(c)) begin
            mode_d = M_IDENT; tstart_d = at; len_d = 16'd1; kw_d = {48'd0, c};
          end else begin
            b = push(b, mk(K_LPAREN, off16(at), 16'd1, 16'd1, line_d, ERR_UNEXPECTED));
          end
        end
      endcase
    end

    // End of text: close the open token, report END unless a string is open, then reset.
    if (in_data_i.last_byte) begin
      unique case (mode_d)
        M_OP:
          b = put(b, sp_cnt_d, off16(sp_start_d), line_d, K_BANG + {3'b000, pend_d, 1'b0},
                  off16(tstart_d), 16'd1);
        M_SLASH:
          b = put(b, sp_cnt_d, off16(sp_start_d), line_d, K_SLASH, off16(tstart_d), 16'd1);
        M_STRING: begin
          b = push(b, mk(K_STRING, off16(tstart_d), len_d, 16'd1, sline_d, ERR_UNTERM));
          broken = 1'b1;
        end
        M_IDENT:
          b = put(b, sp_cnt_d, off16(sp_start_d), line_d, word_kind(len_d, kw_d),
                  off16(tstart_d), len_d);
        M_INT, M_FRAC:
          b = put(b, sp_cnt_d, off16(sp_start_d), line_d, K_NUMBER, off16(tstart_d), len_d);
        M_DOT: begin
          b = put(b, sp_cnt_d, off16(sp_start_d), line_d, K_NUMBER, off16(tstart_d), len_d);
          b = push(b, mk(K_DOT, off16(at), 16'd1, 16'd1, line_d, ERR_NONE));
        end
        default: ;
      endcase
      if (!broken) b = push(b, mk(K_END, off16(pos_d), 16'd0, 16'd1, line_d, ERR_NONE));
      mode_d = M_IDLE; pend_d = '0; pos_d = '0; tstart_d = '0; line_d = 16'd1;
      lht_d = 1'b0; sp_cnt_d = '0; sp_start_d = '0; kw_d = '0; len_d = '0;
      sline_d = 16'd1;
    end
  end

  // Scanner state, updated once per accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE; pend_q <= '0; pos_q <= '0; tstart_q <= '0; line_q <= 16'd1;
      lht_q <= 1'b0; sp_cnt_q <= '0; sp_start_q <= '0; kw_q <= '0; len_q <= '0;
      sline_q <= 16'd1;
    end else if (accept) begin
      mode_q <= mode_d; pend_q <= pend_d; pos_q <= pos_d; tstart_q <= tstart_d;
      line_q <= line_d; lht_q <= lht_d; sp_cnt_q <= sp_cnt_d; sp_start_q <= sp_start_d;
      kw_q <= kw_d; len_q <= len_d; sline_q <= sline_d;
    end
  end

endmodule

### sv/stt_queue.sv
module stt_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  stt_pkg::bundle_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output stt_pkg::bundle_t head_o
);
  import stt_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  bundle_t              mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]     wr_q, rd_q;
  logic [PTR_W:0]       cnt_q;

  assign full_o  = (cnt_q == (PTR_W+1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  // Storage for bundles of results.
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      if (pop_i)  rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      cnt_q <= cnt_q + (PTR_W+1)'(push_i) - (PTR_W+1)'(pop_i);
    end
  end

endmodule

### sv/stt_back.sv
module stt_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  stt_pkg::bundle_t   q_head_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output stt_pkg::out_item_t out_data_o
);
  import stt_pkg::*;

  logic [CNT_W-1:0] idx_q, idx_d;
  logic             is_last;
  token_t           t;

  assign t           = q_head_i.tok[idx_q[$clog2(MAX_RES)-1:0]];
  assign is_last     = (idx_q == q_head_i.count - CNT_W'(1));
  assign out_valid_o = !q_empty_i;
  assign q_pop_o     = out_valid_o && out_ready_i && is_last;

  // Present the current result of the head bundle.
  always_comb begin
    out_data_o.token_kind    = t.kind;
    out_data_o.start_offset  = t.start;
    out_data_o.lexeme_length = t.len;
    out_data_o.repeat_count  = t.rep;
    out_data_o.line_number   = t.line;
    out_data_o.error_code    = t.err;
    out_data_o.last_result   = is_last;
  end

  // Step through the bundle one result per taken item.
  always_comb begin
    idx_d = idx_q;
    if (out_valid_o && out_ready_i) idx_d = is_last ? '0 : idx_q + CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) idx_q <= '0;
    else         idx_q <= idx_d;
  end

endmodule

### sv/source_text_tokenizer_core.sv
// Channel  Dir  Payload                                           Handshake
// in_i     in   char_byte, last_byte                              valid/ready
// out_o    out  token_kind, start_offset, lexeme_length,          valid/ready
//               repeat_count, line_number, error_code, last_result
//
// One source byte is taken per cycle while the result queue is not full.
// A byte yields zero to five items, sent one per cycle while the output is ready,
// so the output port sets the sustained rate once the queue fills.
// A two-entry queue of result bundles sits between scanner and output stage.
// Reset is asynchronous and clears all control state; the scanner returns to its
// reset state by itself after the final byte of a text.
module source_text_tokenizer_core #(
  parameter int OFFSET_BITS   = stt_pkg::OFFSET_BITS_DEF,
  parameter int KEYWORD_COUNT = stt_pkg::KEYWORD_COUNT_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  stt_stream_if.sink   in_i,
  stt_stream_if.source out_o
);
  import stt_pkg::*;

  logic    q_full, q_push, q_pop, q_empty;
  bundle_t q_wdata, q_head;

  stt_front #(
    .OFFSET_BITS  (OFFSET_BITS),
    .KEYWORD_COUNT(KEYWORD_COUNT)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_i.valid),
    .in_data_i (in_i.data),
    .in_ready_o(in_i.ready),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_data_o  (q_wdata)
  );

  stt_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_data_i(q_wdata),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .head_o     (q_head)
  );

  stt_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_head_i   (q_head),
    .q_pop_o    (q_pop),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .out_data_o (out_o.data)
  );

endmodule

### sv/stt_checker.sv
module stt_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input stt_pkg::out_item_t out_data_i
);
  import stt_pkg::*;

  // A stalled item holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled item changed");

  // END closes the byte's results and has no length.
  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.token_kind == K_END |->
      out_data_i.last_result && out_data_i.lexeme_length == 16'd0)
    else $error("malformed END item");

  // An unterminated string is always a string and always final.
  a_unterm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.error_code == ERR_UNTERM |->
      out_data_i.token_kind == K_STRING && out_data_i.last_result)
    else $error("bad unterminated string item");

  // Only merged spaces carry a repeat count other than one.
  a_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.token_kind != K_SPACE |-> out_data_i.repeat_count == 16'd1)
    else $error("repeat count on a non-space item");

endmodule

bind source_text_tokenizer_core stt_checker u_stt_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_data_i (out_o.data)
);
